FILE: hdl/bha_pkg.sv
// Shared constants, codes and types of the buddy heap allocator.
package bha_pkg;

  localparam int unsigned HEAP_BYTES      = 65536;
  localparam int unsigned MIN_BLOCK_BYTES = 64;
  localparam int unsigned NumSlots        = HEAP_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned SlotW           = $clog2(NumSlots);
  localparam int unsigned GranW           = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned TopOrder        = (SlotW > 15) ? 15 : SlotW;

  localparam int unsigned AddrW = 16;
  localparam int unsigned HdrW  = 6;
  localparam int unsigned OrdW  = 4;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADPTR  = 2'd3;

  localparam logic [HdrW-1:0] HDR_RESET = 6'd32;

  typedef struct packed {
    logic [OrdW-1:0] order;
    logic            free;
    logic            head;
  } entry_t;

  typedef struct packed {
    logic [AddrW-1:0] result_address;
    logic [AddrW-1:0] old_address;
    logic [1:0]       status;
  } rsp_t;

  typedef struct packed {
    logic done;
    logic idle;
  } seq_stat_t;

endpackage

FILE: hdl/bha_intf.sv
// Request and response channel interfaces of the buddy heap allocator.
interface bha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] request_bytes;
  logic [15:0] pointer_in;
  modport source (output valid, op, request_bytes, pointer_in, input ready);
  modport sink (input valid, op, request_bytes, pointer_in, output ready);
endinterface

interface bha_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_address;
  logic [15:0] old_address;
  logic [1:0]  status;
  modport source (output valid, result_address, old_address, status, input ready);
  modport sink (input valid, result_address, old_address, status, output ready);
endinterface

FILE: hdl/buddy_heap_allocator.sv
// Top level of the buddy heap allocator: handshakes, header register, result register.
//
//   channel  direction  word
//   req_i    in         op, request_bytes, pointer_in
//   rsp_o    out        result_address, old_address, status
//   cfg      in         header_bytes, written when cfg_we_i is high
//
// After reset a clearing pass initialises the block table; no word is taken
// meanwhile. One word is worked on at a time: a decode step, and for a free or
// resize a pointer check. The first-fit walk reads and checks each block visited,
// then come the split writes, the buddy merge reads and checks and the last
// release write, all bound by the one table port. A final step hands the result
// over, and it stalls while the output register still holds an unaccepted word.
// A finished result waits in the output register while the next word is taken.
module buddy_heap_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bha_req_if.sink                  req_i,
  bha_rsp_if.source                rsp_o,
  input  logic                     cfg_we_i,
  input  logic [bha_pkg::HdrW-1:0] cfg_wdata_i
);
  import bha_pkg::*;

  logic [HdrW-1:0] hdr_q;
  seq_stat_t       stat;
  rsp_t            rsp, rsp_q;
  logic            out_valid_q, slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= HDR_RESET;
    end else if (cfg_we_i) begin
      hdr_q <= cfg_wdata_i;
    end
  end

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = stat.idle;

  bha_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (req_i.valid),
    .op_i        (req_i.op),
    .req_bytes_i (req_i.request_bytes),
    .pointer_i   (req_i.pointer_in),
    .hdr_i       (hdr_q),
    .slot_free_i (slot_free),
    .stat_o      (stat),
    .rsp_o       (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done && slot_free) rsp_q <= rsp;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.result_address = rsp_q.result_address;
  assign rsp_o.old_address    = rsp_q.old_address;
  assign rsp_o.status         = rsp_q.status;
endmodule

FILE: hdl/bha_ram.sv
// Single write port, single registered read port RAM.
module bha_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hdl/bha_size_unit.sv
// Block order needed for a request, and decoding of a data address to a slot.
module bha_size_unit (
  input  logic [15:0]              req_bytes_i,
  input  logic [15:0]              pointer_i,
  input  logic [bha_pkg::HdrW-1:0] hdr_i,
  output logic [bha_pkg::OrdW-1:0] order_o,
  output logic                     order_ok_o,
  output logic [bha_pkg::SlotW-1:0] slot_o,
  output logic                     ptr_ok_o
);
  import bha_pkg::*;

  logic [16:0]         need;
  logic [TopOrder:0]   fits;
  logic [15:0]         base;

  always_comb begin
    need = 17'(req_bytes_i) + 17'(hdr_i);
    for (int k = 0; k <= TopOrder; k++) begin
      fits[k] = (21'(need) <= (21'(MIN_BLOCK_BYTES) << k));
    end
    order_ok_o = |fits;
    order_o    = '0;
    for (int k = TopOrder; k >= 0; k--) begin
      if (fits[k]) begin
        order_o = OrdW'(k);
      end
    end
  end

  assign base     = pointer_i - 16'(hdr_i);
  assign slot_o   = base[GranW +: SlotW];
  assign ptr_ok_o = (pointer_i >= 16'(hdr_i)) && (base[GranW-1:0] == '0);
endmodule

FILE: hdl/bha_seq.sv
// Sequencer that walks, splits and merges blocks in the block table.
module bha_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [1:0]               op_i,
  input  logic [15:0]              req_bytes_i,
  input  logic [15:0]              pointer_i,
  input  logic [bha_pkg::HdrW-1:0] hdr_i,
  input  logic                     slot_free_i,
  output bha_pkg::seq_stat_t       stat_o,
  output bha_pkg::rsp_t            rsp_o
);
  import bha_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_PTR_CHK, S_WALK_RD, S_WALK_CHK,
    S_SPLIT, S_REL_RD, S_REL_CHK, S_REL_END, S_FIN
  } state_e;

  state_e            state_q;
  logic [1:0]        op_q;
  logic [15:0]       req_q, ptr_q;
  logic [OrdW-1:0]   k_q, sord_q, ord_q, rel_ord_q;
  logic              kok_q;
  logic [SlotW-1:0]  s_q, n_q, rel_s_q, clr_q;
  logic [SlotW:0]    i_q;
  rsp_t              rsp_q;

  logic [OrdW-1:0]   u_order;
  logic              u_order_ok, u_ptr_ok;
  logic [SlotW-1:0]  u_slot;

  logic              we;
  logic [SlotW-1:0]  waddr, raddr;
  entry_t            wdata, rdata;
  logic [SlotW-1:0]  buddy, rel_bit;
  logic [OrdW-1:0]   ord_dn;

  bha_size_unit u_size (
    .req_bytes_i (req_q),
    .pointer_i   (ptr_q),
    .hdr_i       (hdr_i),
    .order_o     (u_order),
    .order_ok_o  (u_order_ok),
    .slot_o      (u_slot),
    .ptr_ok_o    (u_ptr_ok)
  );

  logic [$bits(entry_t)-1:0] rdata_raw;

  bha_ram #(.Depth(NumSlots), .Width($bits(entry_t))) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata   = entry_t'(rdata_raw);
  assign rel_bit = SlotW'(1) << rel_ord_q;
  assign buddy   = rel_s_q ^ rel_bit;
  assign ord_dn  = ord_q - OrdW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        if (clr_q == '0) begin
          wdata = '{order: OrdW'(TopOrder), free: 1'b1, head: 1'b1};
        end
      end
      S_DECODE:  raddr = u_slot;
      S_WALK_RD: raddr = i_q[SlotW-1:0];
      S_REL_RD:  raddr = buddy;
      S_SPLIT: begin
        we = 1'b1;
        if (ord_q > k_q) begin
          waddr = n_q + (SlotW'(1) << ord_dn);
          wdata = '{order: ord_dn, free: 1'b1, head: 1'b1};
        end else begin
          waddr = n_q;
          wdata = '{order: k_q, free: 1'b0, head: 1'b1};
        end
      end
      S_REL_CHK: begin
        // The upper half of a merged pair stops being a block head.
        if (rdata.head && rdata.free && rdata.order == rel_ord_q) begin
          we    = 1'b1;
          waddr = rel_s_q | rel_bit;
        end
      end
      S_REL_END: begin
        we    = 1'b1;
        waddr = rel_s_q;
        wdata = '{order: rel_ord_q, free: 1'b1, head: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      op_q      <= '0;
      req_q     <= '0;
      ptr_q     <= '0;
      k_q       <= '0;
      kok_q     <= 1'b0;
      sord_q    <= '0;
      ord_q     <= '0;
      rel_ord_q <= '0;
      s_q       <= '0;
      n_q       <= '0;
      rel_s_q   <= '0;
      i_q       <= '0;
      rsp_q     <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SlotW'(1);
          if (&clr_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            op_q    <= op_i;
            req_q   <= req_bytes_i;
            ptr_q   <= pointer_i;
            rsp_q   <= '0;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          k_q   <= u_order;
          kok_q <= u_order_ok;
          s_q   <= u_slot;
          i_q   <= '0;
          priority if (op_q == OP_ALLOC || (op_q == OP_RESIZE && ptr_q == '0)) begin
            if (req_q == '0) begin
              rsp_q.status <= ST_NULL;
              state_q      <= S_FIN;
            end else if (!u_order_ok) begin
              rsp_q.status <= ST_NOSPACE;
              state_q      <= S_FIN;
            end else begin
              state_q <= S_WALK_RD;
            end
          end else if (op_q == OP_FREE || op_q == OP_RESIZE) begin
            if (ptr_q == '0 || (op_q == OP_RESIZE && req_q == '0)) begin
              rsp_q.status <= ST_NULL;
              state_q      <= S_FIN;
            end else if (!u_ptr_ok) begin
              rsp_q.status <= ST_BADPTR;
              state_q      <= S_FIN;
            end else begin
              state_q <= S_PTR_CHK;
            end
          end else begin
            state_q <= S_FIN;
          end
        end
        S_PTR_CHK: begin
          sord_q <= rdata.order;
          if (!rdata.head || rdata.free) begin
            rsp_q.status <= ST_BADPTR;
            state_q      <= S_FIN;
          end else if (op_q == OP_FREE) begin
            rel_s_q   <= s_q;
            rel_ord_q <= rdata.order;
            state_q   <= S_REL_RD;
          end else if (kok_q && k_q == rdata.order) begin
            rsp_q.result_address <= ptr_q;
            state_q              <= S_FIN;
          end else if (!kok_q) begin
            rsp_q.status <= ST_NOSPACE;
            state_q      <= S_FIN;
          end else begin
            state_q <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          if (i_q[SlotW]) begin
            rsp_q.status <= ST_NOSPACE;
            state_q      <= S_FIN;
          end else begin
            state_q <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (rdata.head && rdata.free && rdata.order >= k_q) begin
            n_q     <= i_q[SlotW-1:0];
            ord_q   <= rdata.order;
            state_q <= S_SPLIT;
          end else begin
            i_q     <= i_q + ((SlotW+1)'(1) << rdata.order);
            state_q <= S_WALK_RD;
          end
        end
        S_SPLIT: begin
          if (ord_q > k_q) begin
            ord_q <= ord_dn;
          end else begin
            rsp_q.result_address <= AddrW'({n_q, {GranW{1'b0}}}) + AddrW'(hdr_i);
            if (op_q == OP_RESIZE && ptr_q != '0) begin
              rsp_q.old_address <= ptr_q;
              rel_s_q           <= s_q;
              rel_ord_q         <= sord_q;
              state_q           <= S_REL_RD;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_REL_RD: begin
          state_q <= (rel_ord_q >= OrdW'(TopOrder)) ? S_REL_END : S_REL_CHK;
        end
        S_REL_CHK: begin
          if (rdata.head && rdata.free && rdata.order == rel_ord_q) begin
            rel_s_q   <= rel_s_q & ~rel_bit;
            rel_ord_q <= rel_ord_q + OrdW'(1);
            state_q   <= S_REL_RD;
          end else begin
            state_q <= S_REL_END;
          end
        end
        S_REL_END: state_q <= S_FIN;
        S_FIN: begin
          if (slot_free_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign stat_o.done = (state_q == S_FIN);
  assign stat_o.idle = (state_q == S_IDLE);
  assign rsp_o       = rsp_q;
endmodule

FILE: hdl/bha_checker.sv
// Port-level checks of the buddy heap allocator and their binding.
module bha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] result_address_i,
  input logic [15:0] old_address_i,
  input logic [1:0]  status_i
);
  import bha_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(result_address_i))
    else $error("response changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("new word taken while one is in progress");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_OK |-> result_address_i == '0 && old_address_i == '0)
    else $error("failed request carries an address");

  a_old_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && old_address_i != '0 |-> status_i == ST_OK)
    else $error("released address reported without success");
endmodule

bind buddy_heap_allocator bha_checker u_bha_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .result_address_i (rsp_o.result_address),
  .old_address_i    (rsp_o.old_address),
  .status_i         (rsp_o.status)
);
